// ===== rtl/ltb_pkg.sv =====
// ----------------------------------------------------------------------------
// ltb_pkg
// Types, constants and helper functions shared by the LIN frame builder.
// ----------------------------------------------------------------------------
`default_nettype none

package ltb_pkg;

   // framing constants
   localparam logic [7:0] SYNC_BYTE          = 8'h55;
   localparam logic [5:0] ID_MASK            = 6'h3F;
   localparam int         MAX_DATA_BYTES_DEF = 8;
   localparam int         QUEUE_DEPTH_DEF    = 2;
   localparam int         CNT_W              = 4;

   // back-end sequencer steps
   localparam logic [2:0] STEP_BREAK = 3'd0;
   localparam logic [2:0] STEP_SYNC  = 3'd1;
   localparam logic [2:0] STEP_PID   = 3'd2;
   localparam logic [2:0] STEP_DATA  = 3'd3;
   localparam logic [2:0] STEP_CKS   = 3'd4;

   // input item
   typedef struct packed {
      logic [5:0] frame_id;
      logic [7:0] data_byte;
      logic       first_byte;
      logic       last_byte;
   } req_item_type;

   // result item
   typedef struct packed {
      logic [7:0] tx_byte;
      logic       break_marker;
      logic       frame_end;
      logic       overflow;
   } rsp_item_type;

   // classified work passed from front to back
   typedef struct packed {
      logic       head;
      logic [7:0] pid;
      logic       ovf;
      logic [7:0] data;
      logic       cks;
      logic [7:0] cks_byte;
   } cmd_type;

   // protected identifier with parity bits p0 and p1
   function automatic logic [7:0] protect_id(input logic [5:0] id);
      logic p0;
      logic p1;
      p0 = id[0] ^ id[1] ^ id[2] ^ id[4];
      p1 = ~(id[1] ^ id[3] ^ id[4] ^ id[5]);
      return {p1, p0, id & ID_MASK};
   endfunction

   // 8-bit sum with end-around carry
   function automatic logic [7:0] sum_carry(input logic [7:0] a, input logic [7:0] b);
      logic [8:0] s;
      s = {1'b0, a} + {1'b0, b};
      return s[8] ? (s[7:0] + 8'd1) : s[7:0];
   endfunction

endpackage

`default_nettype wire

// ===== rtl/ltb_front.sv =====
// ----------------------------------------------------------------------------
// ltb_front
// Accepts data bytes, tracks frame state and checksum, pushes one command
// per item that produces output.
// ----------------------------------------------------------------------------
`default_nettype none

module ltb_front #(
   parameter int MAX_DATA_BYTES = ltb_pkg::MAX_DATA_BYTES_DEF
) (
   input  wire                   clock,
   input  wire                   reset,
   input  wire                   req_valid,
   output logic                  req_stall,
   input  ltb_pkg::req_item_type req_item,
   input  wire                   q_full,
   output logic                  q_push,
   output ltb_pkg::cmd_type      q_cmd
);

   logic [7:0]                 sum_ff, sum_in;
   logic [ltb_pkg::CNT_W-1:0]  cnt_ff, cnt_in;
   logic                       open_ff, open_in;

   logic                       accept;
   logic [7:0]                 pid;
   logic [7:0]                 sum_base;
   logic [7:0]                 sum_new;
   logic [ltb_pkg::CNT_W-1:0]  cnt_base;
   logic                       ovf;

   assign req_stall = q_full;
   assign accept    = req_valid & ~req_stall;

   // classify the item against the open frame
   always_comb begin
      pid      = ltb_pkg::protect_id(req_item.frame_id);
      sum_base = req_item.first_byte ? pid : sum_ff;
      cnt_base = req_item.first_byte ? '0 : cnt_ff;
      ovf      = ~(cnt_base < ltb_pkg::CNT_W'(MAX_DATA_BYTES));
      sum_new  = ovf ? sum_base : ltb_pkg::sum_carry(sum_base, req_item.data_byte);
   end

   // command to the back end
   always_comb begin
      q_push         = accept & (req_item.first_byte | open_ff);
      q_cmd.head     = req_item.first_byte;
      q_cmd.pid      = pid;
      q_cmd.ovf      = ovf;
      q_cmd.data     = req_item.data_byte;
      q_cmd.cks      = req_item.last_byte;
      q_cmd.cks_byte = ~sum_new;
   end

   // frame state update
   always_comb begin
      sum_in  = sum_ff;
      cnt_in  = cnt_ff;
      open_in = open_ff;
      if (q_push) begin
         if (req_item.last_byte) begin
            sum_in  = '0;
            cnt_in  = '0;
            open_in = 1'b0;
         end else begin
            sum_in  = sum_new;
            cnt_in  = ovf ? cnt_base : cnt_base + ltb_pkg::CNT_W'(1);
            open_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sum_ff  <= '0;
         cnt_ff  <= '0;
         open_ff <= 1'b0;
      end else begin
         sum_ff  <= sum_in;
         cnt_ff  <= cnt_in;
         open_ff <= open_in;
      end
   end

endmodule

`default_nettype wire

// ===== rtl/ltb_queue.sv =====
// ----------------------------------------------------------------------------
// ltb_queue
// Small register queue of commands between the front and back ends.
// ----------------------------------------------------------------------------
`default_nettype none

module ltb_queue #(
   parameter int DEPTH = ltb_pkg::QUEUE_DEPTH_DEF
) (
   input  wire              clock,
   input  wire              reset,
   input  wire              push,
   input  ltb_pkg::cmd_type push_cmd,
   output logic             full,
   input  wire              pop,
   output ltb_pkg::cmd_type head_cmd,
   output logic             empty
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   ltb_pkg::cmd_type   slot_ff [DEPTH];
   logic [PTR_W-1:0]   wr_ff, wr_in;
   logic [PTR_W-1:0]   rd_ff, rd_in;
   logic [CNT_W-1:0]   cnt_ff, cnt_in;
   logic               do_push;
   logic               do_pop;

   assign full     = (cnt_ff == CNT_W'(DEPTH));
   assign empty    = (cnt_ff == '0);
   assign head_cmd = slot_ff[rd_ff];
   assign do_push  = push & ~full;
   assign do_pop   = pop & ~empty;

   // pointer wrap at depth
   always_comb begin
      wr_in  = wr_ff;
      rd_in  = rd_ff;
      cnt_in = cnt_ff;
      if (do_push) begin
         wr_in = (wr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ff + PTR_W'(1);
      end
      if (do_pop) begin
         rd_in = (rd_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ff + PTR_W'(1);
      end
      if (do_push & ~do_pop) begin
         cnt_in = cnt_ff + CNT_W'(1);
      end else if (do_pop & ~do_push) begin
         cnt_in = cnt_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

   // storage
   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ff] <= push_cmd;
      end
   end

endmodule

`default_nettype wire

// ===== rtl/ltb_back.sv =====
// ----------------------------------------------------------------------------
// ltb_back
// Sequencer that expands one command into its result bytes, one per cycle
// while the output is not stalled, into an output register.
// ----------------------------------------------------------------------------
`default_nettype none

module ltb_back (
   input  wire                   clock,
   input  wire                   reset,
   input  wire                   q_empty,
   input  ltb_pkg::cmd_type      q_head,
   output logic                  q_pop,
   output logic                  rsp_valid,
   input  wire                   rsp_stall,
   output ltb_pkg::rsp_item_type rsp_item
);

   ltb_pkg::cmd_type      cur_ff, cur_in;
   logic                  cur_valid_ff, cur_valid_in;
   logic [2:0]            step_ff, step_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   ltb_pkg::rsp_item_type rsp_ff, rsp_in;

   logic                  out_take;
   logic                  emit;
   logic                  last_step;
   ltb_pkg::rsp_item_type step_out;
   logic [2:0]            step_next;

   assign out_take  = ~rsp_valid_ff | ~rsp_stall;
   assign emit      = cur_valid_ff & out_take;
   assign last_step = (step_ff == ltb_pkg::STEP_CKS)
                    | ((step_ff == ltb_pkg::STEP_DATA) & ~cur_ff.cks);
   assign q_pop     = ~q_empty & (~cur_valid_ff | (emit & last_step));
   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_ff;

   // result for the current step
   always_comb begin
      step_out  = '0;
      step_next = step_ff;
      case (step_ff)
         ltb_pkg::STEP_BREAK: begin
            step_out.break_marker = 1'b1;
            step_next             = ltb_pkg::STEP_SYNC;
         end
         ltb_pkg::STEP_SYNC: begin
            step_out.tx_byte = ltb_pkg::SYNC_BYTE;
            step_next        = ltb_pkg::STEP_PID;
         end
         ltb_pkg::STEP_PID: begin
            step_out.tx_byte = cur_ff.pid;
            step_next        = ltb_pkg::STEP_DATA;
         end
         ltb_pkg::STEP_DATA: begin
            step_out.tx_byte  = cur_ff.ovf ? 8'h00 : cur_ff.data;
            step_out.overflow = cur_ff.ovf;
            step_next         = ltb_pkg::STEP_CKS;
         end
         ltb_pkg::STEP_CKS: begin
            step_out.tx_byte   = cur_ff.cks_byte;
            step_out.frame_end = 1'b1;
            step_next          = ltb_pkg::STEP_CKS;
         end
         default: begin
            step_out  = '0;
            step_next = ltb_pkg::STEP_CKS;
         end
      endcase
   end

   // command holding register and step counter
   always_comb begin
      cur_in       = cur_ff;
      cur_valid_in = cur_valid_ff;
      step_in      = step_ff;
      if (emit) begin
         step_in = step_next;
         if (last_step) begin
            cur_valid_in = 1'b0;
         end
      end
      if (q_pop) begin
         cur_in       = q_head;
         cur_valid_in = 1'b1;
         step_in      = q_head.head ? ltb_pkg::STEP_BREAK : ltb_pkg::STEP_DATA;
      end
   end

   // output register
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_in       = rsp_ff;
      if (out_take) begin
         rsp_valid_in = cur_valid_ff;
         rsp_in       = step_out;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cur_valid_ff <= 1'b0;
         step_ff      <= ltb_pkg::STEP_BREAK;
         rsp_valid_ff <= 1'b0;
      end else begin
         cur_valid_ff <= cur_valid_in;
         step_ff      <= step_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_ff <= cur_in;
      rsp_ff <= rsp_in;
   end

endmodule

`default_nettype wire

// ===== rtl/lin_frame_transmit_builder_core.sv =====
// ----------------------------------------------------------------------------
// lin_frame_transmit_builder_core
// Builds LIN 2.0 frame bytes: break, sync, protected id, data, enhanced
// checksum.
//
//   channel   ports        direction  payload
//   request   req_*        in         data byte, frame id, first/last marks
//   response  rsp_*        out        tx byte, break, frame end, overflow
//
// An item gives one to five result bytes, one per cycle from the back-end
// sequencer while the output is not stalled; a frame start with data and
// checksum gives five. A byte with no frame open gives no result.
// A first result passes the command queue, holding and output registers.
// Reset clears frame state, queue and output register.
// The command queue lets the front accept items while the output is stalled.
// ----------------------------------------------------------------------------
`default_nettype none

module lin_frame_transmit_builder_core #(
   parameter int MAX_DATA_BYTES = ltb_pkg::MAX_DATA_BYTES_DEF,
   parameter int QUEUE_DEPTH    = ltb_pkg::QUEUE_DEPTH_DEF
) (
   input  wire                   clock,
   input  wire                   reset,
   input  wire                   req_valid,
   output logic                  req_stall,
   input  ltb_pkg::req_item_type req_item,
   output logic                  rsp_valid,
   input  wire                   rsp_stall,
   output ltb_pkg::rsp_item_type rsp_item
);

   logic             q_full;
   logic             q_empty;
   logic             q_push;
   logic             q_pop;
   ltb_pkg::cmd_type q_cmd;
   ltb_pkg::cmd_type q_head;

   // front end: frame state and checksum
   ltb_front #(
      .MAX_DATA_BYTES (MAX_DATA_BYTES)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_item  (req_item),
      .q_full    (q_full),
      .q_push    (q_push),
      .q_cmd     (q_cmd)
   );

   // command queue
   ltb_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (q_push),
      .push_cmd (q_cmd),
      .full     (q_full),
      .pop      (q_pop),
      .head_cmd (q_head),
      .empty    (q_empty)
   );

   // back end: byte sequencer
   ltb_back u_back (
      .clock     (clock),
      .reset     (reset),
      .q_empty   (q_empty),
      .q_head    (q_head),
      .q_pop     (q_pop),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_item  (rsp_item)
   );

endmodule

`default_nettype wire

// ===== bench/lin_frame_transmit_builder_core_test.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// lin_frame_transmit_builder_core_test
// Self-checking bench for the LIN frame builder. It sends data bytes with
// first/last marks and frame ids, and predicts the break, sync, protected id,
// data, overflow and checksum results of each one. Every result is checked in
// order while both channels idle at random and the receiver holds off once
// for a long stretch.
// ----------------------------------------------------------------------------
module lin_frame_transmit_builder_core_test;

   localparam int HALF_PERIOD        = 6;
   localparam int RESET_CYCLES       = 5;
   localparam int RANDOM_ITEMS       = 460;
   localparam int MAX_BYTES          = ltb_pkg::MAX_DATA_BYTES_DEF;
   localparam int LONG_HOLD          = 100;
   localparam int HOLD_AFTER_RESULTS = 300;
   localparam int WATCHDOG_LIMIT     = 2000;
   localparam int DRAIN_CYCLES       = 30;
   localparam int REPORT_LIMIT       = 10;

   logic                  clock     = 1'b0;
   logic                  reset     = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_stall;
   ltb_pkg::req_item_type req_item  = '0;
   logic                  rsp_valid;
   logic                  rsp_stall = 1'b0;
   ltb_pkg::rsp_item_type rsp_item;

   // items waiting to be sent and results still owed by the block
   ltb_pkg::req_item_type pending_q[$];
   ltb_pkg::rsp_item_type expected_bytes_q[$];
   bit           gen_frame_open = 1'b0;
   int           gen_counted    = 0;
   int           n_queued       = 0;
   bit           quiet_phase    = 1'b0;

   // predicted frame state
   logic [7:0] ck_sum;
   logic [3:0] data_cnt;
   logic       frame_active;

   // run statistics
   int items_taken      = 0;
   int results_seen     = 0;
   int frames_closed    = 0;
   int frames_abandoned = 0;
   int drops            = 0;
   int ignored          = 0;
   int mismatches       = 0;
   bit long_hold_done   = 1'b0;

   lin_frame_transmit_builder_core dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_item  (req_item),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_item  (rsp_item)
   );

   // clock
   always #HALF_PERIOD clock = ~clock;

   // identifier with p0 in bit 6 and inverted-odd p1 in bit 7
   function automatic logic [7:0] pid_of(input logic [5:0] id);
      logic p0;
      logic p1;
      p0 = ^(id & 6'b010111);
      p1 = ~^(id & 6'b111010);
      return {p1, p0, id};
   endfunction

   // 8-bit add, a carry out wraps back into bit 0
   function automatic logic [7:0] add_end_around(input logic [7:0] a, input logic [7:0] b);
      logic [8:0] s;
      s = {1'b0, a} + {1'b0, b};
      if (s > 9'd255) s = s - 9'd255;
      return s[7:0];
   endfunction

   function automatic ltb_pkg::rsp_item_type out_byte(input logic [7:0] tx,
                                                      input logic brk,
                                                      input logic fend,
                                                      input logic ovf);
      ltb_pkg::rsp_item_type r;
      r.tx_byte      = tx;
      r.break_marker = brk;
      r.frame_end    = fend;
      r.overflow     = ovf;
      return r;
   endfunction

   // results of one accepted item, pushed in transmit order
   task automatic build_frame_bytes(input ltb_pkg::req_item_type it);
      logic [7:0] pid;
      pid = pid_of(it.frame_id);
      if (it.first_byte) begin
         if (frame_active) frames_abandoned++;
         expected_bytes_q.push_back(out_byte(8'h00, 1'b1, 1'b0, 1'b0));
         expected_bytes_q.push_back(out_byte(ltb_pkg::SYNC_BYTE, 1'b0, 1'b0, 1'b0));
         expected_bytes_q.push_back(out_byte(pid, 1'b0, 1'b0, 1'b0));
         ck_sum       = pid;
         data_cnt     = '0;
         frame_active = 1'b1;
      end else if (!frame_active) begin
         ignored++;
         return;
      end
      if (data_cnt < MAX_BYTES) begin
         expected_bytes_q.push_back(out_byte(it.data_byte, 1'b0, 1'b0, 1'b0));
         ck_sum   = add_end_around(ck_sum, it.data_byte);
         data_cnt = data_cnt + 4'd1;
      end else begin
         expected_bytes_q.push_back(out_byte(8'h00, 1'b0, 1'b0, 1'b1));
         drops++;
      end
      if (it.last_byte) begin
         expected_bytes_q.push_back(out_byte(~ck_sum, 1'b0, 1'b1, 1'b0));
         ck_sum       = '0;
         data_cnt     = '0;
         frame_active = 1'b0;
         frames_closed++;
      end
   endtask

   // queue one item, counting it unless the block will ignore it
   task automatic queue_byte(input logic [5:0] id, input logic [7:0] data,
                             input bit first, input bit last);
      ltb_pkg::req_item_type it;
      it.frame_id   = id;
      it.data_byte  = data;
      it.first_byte = first;
      it.last_byte  = last;
      pending_q.push_back(it);
      if (first || gen_frame_open) gen_counted++;
      if (first) gen_frame_open = 1'b1;
      if (last) gen_frame_open = 1'b0;
   endtask

   // mostly legal lengths, some past the byte limit, a few cut short
   task automatic queue_random_frame();
      int len;
      bit cut;
      len = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 11) : $urandom_range(1, 8);
      cut = ($urandom_range(0, 11) == 0);
      for (int k = 0; k < len; k++)
         queue_byte(6'($urandom_range(0, 63)), 8'($urandom_range(0, 255)), k == 0,
                    (k == len - 1) && !cut);
   endtask

   // request driver
   int send_gap = 0;
   always @(posedge clock) begin
      if (reset) begin
         req_valid    <= 1'b0;
         ck_sum       = '0;
         data_cnt     = '0;
         frame_active = 1'b0;
         send_gap     = 0;
      end else begin
         if (req_valid && !req_stall) begin
            build_frame_bytes(req_item);
            pending_q.delete(0);
            items_taken++;
         end
         // a stalled item stays on the bus unchanged
         if (!(req_valid && req_stall)) begin
            if (send_gap > 0) begin
               req_valid <= 1'b0;
               send_gap--;
            end else if (pending_q.size() != 0 && !quiet_phase &&
                         $urandom_range(0, 7) == 0) begin
               req_valid <= 1'b0;
               send_gap = $urandom_range(0, 4);
            end else if (pending_q.size() != 0) begin
               req_valid <= 1'b1;
               req_item  <= pending_q[0];
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // receiver stall: short random bursts plus one long hold
   int stall_gap     = 0;
   int hold_left     = 0;
   int results_local = 0;
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) results_local++;
         if (hold_left > 0) begin
            rsp_stall <= 1'b1;
            hold_left--;
         end else if (!long_hold_done && results_local >= HOLD_AFTER_RESULTS) begin
            rsp_stall <= 1'b1;
            hold_left = LONG_HOLD - 1;
            long_hold_done = 1'b1;
         end else if (stall_gap > 0) begin
            rsp_stall <= 1'b1;
            stall_gap--;
         end else if (!quiet_phase && $urandom_range(0, 7) == 0) begin
            rsp_stall <= 1'b1;
            stall_gap = $urandom_range(0, 4);
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   // result monitor
   always @(posedge clock) begin : result_check
      ltb_pkg::rsp_item_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         results_seen++;
         if (expected_bytes_q.size() == 0) begin
            mismatches++;
            if (mismatches <= REPORT_LIMIT)
               $display("unexpected result: tx_byte %h break %b end %b ovf %b",
                        rsp_item.tx_byte, rsp_item.break_marker,
                        rsp_item.frame_end, rsp_item.overflow);
         end else begin
            want = expected_bytes_q.pop_front();
            // tx_byte carries no meaning on a break result
            if ((!want.break_marker && rsp_item.tx_byte !== want.tx_byte) ||
                rsp_item.break_marker !== want.break_marker ||
                rsp_item.frame_end !== want.frame_end ||
                rsp_item.overflow !== want.overflow) begin
               mismatches++;
               if (mismatches <= REPORT_LIMIT)
                  $display({"mismatch at result %0d (exp/got): ",
                            "tx_byte %h/%h break %b/%b end %b/%b ovf %b/%b"},
                           results_seen, want.tx_byte, rsp_item.tx_byte,
                           want.break_marker, rsp_item.break_marker,
                           want.frame_end, rsp_item.frame_end,
                           want.overflow, rsp_item.overflow);
            end
         end
      end
   end

   // watchdog on cycles with no handshake on either side
   int idle_cycles = 0;
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("no progress for %0d cycles, %0d results outstanding",
                  WATCHDOG_LIMIT, expected_bytes_q.size());
         $display("FAIL lin_frame_transmit_builder_core");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   // stimulus and end of run
   initial begin
      int target;
      // stray bytes with no frame open are dropped silently
      queue_byte(6'h3F, 8'hAA, 1'b0, 1'b0);
      queue_byte(6'h00, 8'h55, 1'b0, 1'b1);
      // one-byte frames at the field extremes
      queue_byte(6'h00, 8'h00, 1'b1, 1'b1);
      queue_byte(6'h3F, 8'hFF, 1'b1, 1'b1);
      // full frame of 0xff exercises the carry wrap, then two dropped bytes
      queue_byte(6'h15, 8'hFF, 1'b1, 1'b0);
      for (int k = 1; k < MAX_BYTES; k++) queue_byte(6'h2A, 8'hFF, 1'b0, 1'b0);
      queue_byte(6'h00, 8'h12, 1'b0, 1'b0);
      queue_byte(6'h3F, 8'h34, 1'b0, 1'b1);
      // open frame abandoned by a new first byte
      queue_byte(6'h2A, 8'h80, 1'b1, 1'b0);
      queue_byte(6'h00, 8'h80, 1'b0, 1'b0);
      queue_byte(6'h01, 8'h01, 1'b1, 1'b0);
      queue_byte(6'h10, 8'hFE, 1'b0, 1'b1);

      // random frames with some stray noise bytes
      target = gen_counted + RANDOM_ITEMS;
      while (gen_counted < target) begin
         if ($urandom_range(0, 9) == 0)
            queue_byte(6'($urandom_range(0, 63)), 8'($urandom_range(0, 255)), 1'b0,
                       1'($urandom_range(0, 1)));
         else
            queue_random_frame();
      end
      n_queued = pending_q.size();

      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      // last part of the run goes without idling
      while (pending_q.size() > n_queued / 6) @(negedge clock);
      quiet_phase <= 1'b1;

      while (pending_q.size() != 0 || req_valid || expected_bytes_q.size() != 0)
         @(negedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (expected_bytes_q.size() != 0) begin
         $display("%0d expected results never arrived", expected_bytes_q.size());
         mismatches += expected_bytes_q.size();
      end

      $display("sent %0d items (%0d ignored), checked %0d results over %0d closed frames",
               items_taken, ignored, results_seen, frames_closed);
      $display("abandoned frames %0d, dropped bytes %0d, long receiver hold %s",
               frames_abandoned, drops, long_hold_done ? "done" : "not reached");
      if (mismatches == 0)
         $display("PASS lin_frame_transmit_builder_core");
      else
         $display("FAIL lin_frame_transmit_builder_core");
      $finish;
   end

endmodule
